// ===== rtl/core/mutex_with_fifo_waitlist_core_assert.svh =====
// Assertion macros used by the mutex core's wait-list module.
`ifndef MUTEX_WITH_FIFO_WAITLIST_CORE_ASSERT_SVH
`define MUTEX_WITH_FIFO_WAITLIST_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define MWFW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define MWFW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mwfw_pkg.sv =====
// Package with the types and constants of the mutex core.
package mwfw_pkg;

    localparam int MAX_TASKS = 16;
    localparam int ID_W      = 4;
    localparam int ID_SPACE  = 1 << ID_W;
    localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int SUM_W     = IDX_W + 1;

    typedef enum logic
    {
        CMD_LOCK   = 1'b0,
        CMD_UNLOCK = 1'b1
    } cmd_t;

    typedef enum logic [2:0]
    {
        ST_ACQUIRED   = 3'd0,
        ST_QUEUED     = 3'd1,
        ST_RELEASED   = 3'd2,
        ST_HANDED_OFF = 3'd3,
        ST_ALREADY    = 3'd4,
        ST_FULL       = 3'd5,
        ST_NOT_LOCKED = 3'd6
    } status_t;

    typedef struct packed
    {
        cmd_t              command;
        logic [ID_W-1:0]   task_id;
    } request_t;

    typedef struct packed
    {
        status_t           status;
        logic [ID_W-1:0]   woken_task;
        logic              woken_valid;
    } result_t;

endpackage

// ===== rtl/core/mwfw_waitlist.sv =====
// Mutex state, wait queue and the per-request decision logic.
module mwfw_waitlist
    import mwfw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  request_t req,
    output result_t  res
);

`include "mutex_with_fifo_waitlist_core_assert.svh"

    logic                lock_held_reg, lock_held_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ID_SPACE-1:0] waiting_mask_reg, waiting_mask_next;
    logic [ID_W-1:0]     wait_queue_reg [MAX_TASKS];

    logic                push;
    logic [SUM_W-1:0]    tail_sum;
    logic [IDX_W-1:0]    tail_idx;
    logic [ID_W-1:0]     head_id;
    logic                full;

    assign full     = (count_reg == CNT_W'(MAX_TASKS));
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_idx = (tail_sum >= SUM_W'(MAX_TASKS))
                    ? IDX_W'(tail_sum - SUM_W'(MAX_TASKS))
                    : IDX_W'(tail_sum);
    assign head_id  = wait_queue_reg[head_reg];

    always_comb
    begin
        lock_held_next    = lock_held_reg;
        head_next         = head_reg;
        count_next        = count_reg;
        waiting_mask_next = waiting_mask_reg;
        push              = 1'b0;
        res.status        = ST_ACQUIRED;
        res.woken_task    = '0;
        res.woken_valid   = 1'b0;
        unique case (req.command)
            CMD_LOCK:
            begin
                priority if (waiting_mask_reg[req.task_id])
                begin
                    res.status = ST_ALREADY;
                end
                else if (!lock_held_reg)
                begin
                    lock_held_next = 1'b1;
                    res.status     = ST_ACQUIRED;
                end
                else if (full)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    push                           = 1'b1;
                    count_next                     = count_reg + 1'b1;
                    waiting_mask_next[req.task_id] = 1'b1;
                    res.status                     = ST_QUEUED;
                end
            end
            CMD_UNLOCK:
            begin
                priority if (!lock_held_reg)
                begin
                    res.status = ST_NOT_LOCKED;
                end
                else if (count_reg != '0)
                begin
                    // hand ownership straight to the oldest waiter
                    head_next = (head_reg == IDX_W'(MAX_TASKS - 1))
                              ? '0 : head_reg + 1'b1;
                    count_next                 = count_reg - 1'b1;
                    waiting_mask_next[head_id] = 1'b0;
                    res.status                 = ST_HANDED_OFF;
                    res.woken_task             = head_id;
                    res.woken_valid            = 1'b1;
                end
                else
                begin
                    lock_held_next = 1'b0;
                    res.status     = ST_RELEASED;
                end
            end
            default:
            begin
                res.status = ST_NOT_LOCKED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_held_reg    <= 1'b0;
            head_reg         <= '0;
            count_reg        <= '0;
            waiting_mask_reg <= '0;
        end
        else if (step)
        begin
            lock_held_reg    <= lock_held_next;
            head_reg         <= head_next;
            count_reg        <= count_next;
            waiting_mask_reg <= waiting_mask_next;
        end
    end

    // queue storage has no reset; only pushed entries are ever read
    always_ff @(posedge clk)
    begin
        if (step && push)
        begin
            wait_queue_reg[tail_idx] <= req.task_id;
        end
    end

    `MWFW_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_TASKS), "queue count over depth")
    `MWFW_ASSERT_NOW(a_mask_matches_count, 1'b1,
        $countones(waiting_mask_reg) == 32'(count_reg), "waiting mask out of step with count")
    `MWFW_ASSERT_NOW(a_waiters_need_owner, count_reg != '0, lock_held_reg,
        "waiters queued on a free mutex")
    `MWFW_ASSERT_NEXT(a_handoff_pops, step && res.woken_valid,
        count_reg == $past(count_reg) - 1'b1, "hand-off did not pop the queue")

endmodule

// ===== rtl/core/mutex_with_fifo_waitlist_core.sv =====
// Top level of the hardware mutex with a FIFO wait list.
//
// One mutex shared by up to MAX_TASKS waiting tasks (task ids 0..15). Each
// request word carries a command (lock or unlock) and a task id, and yields
// exactly one result word: a status code, plus the id of the task woken when
// an unlock hands the mutex to the oldest waiter. The mutex records no owner,
// so an unlock from any task is taken; a lock from a task already waiting is
// refused as a deadlock, and a lock with the queue full is refused too.
// Throughput is one request word per clock cycle while the result side takes
// its words. A word goes into an input register, the state update (flag
// test, mask test, one queue push or pop) runs as it leaves there, and
// the result lands in an output register. A stalled result holds the word in
// the input register and stops the next request word from being taken.
// There is no clearing pass after reset: the wait queue entries need none.
module mutex_with_fifo_waitlist_core
    import mwfw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  request_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output result_t  rsp
);

    // input register
    logic     s1_valid_reg, s1_valid_next;
    request_t s1_req_reg;

    // result register
    logic     rsp_valid_reg, rsp_valid_next;
    result_t  rsp_reg;

    logic     advance;
    result_t  step_res;

    // move the held word into the result register when that slot is free
    assign advance   = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_valid && req_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (advance)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers: load only, no reset
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_req_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= step_res;
        end
    end

    // decide and commit the state change as the word leaves the input register
    mwfw_waitlist u_waitlist
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .req   (s1_req_reg),
        .res   (step_res)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== tb/tb_mutex_with_fifo_waitlist_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the FIFO-waitlist mutex core: directed and random request words.
module tb_mutex_with_fifo_waitlist_core;
    import mwfw_pkg::*;

    localparam int RANDOM_WORDS    = 1150;
    localparam int HOLD_OFF_AFTER  = 400;   // results seen before the long hold-off
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int DRAIN_CYCLES    = 10;    // margin for any stray result word

    // One row of the directed table. Where typed is set, want is the result
    // read straight off the behaviour; otherwise the mutex predictor decides.
    typedef struct
    {
        request_t word;
        bit       typed;
        result_t  want;
    } stim_row_t;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    request_t req;
    logic     rsp_valid;
    logic     rsp_ready;
    result_t  rsp;

    // Mirror of the mutex state: held flag, circular wait list, waiting mask.
    logic                held;
    logic [ID_W-1:0]     waitlist [MAX_TASKS];
    int unsigned         head_idx;
    int unsigned         waiter_count;
    logic [ID_SPACE-1:0] waiter_mask;

    result_t   pending_results [$];   // results owed by the block, oldest first
    stim_row_t stim_table [$];
    int        error_count  = 0;
    int        results_seen = 0;
    bit        no_idle      = 1'b0;   // set for stretches with no gaps on either side

    mutex_with_fifo_waitlist_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Assert reset once at the start, and never again.
    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Hard limit on run time: far above the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Gap length for either side: mostly none, some short, a few long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 65)
            return 0;
        else if (roll < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Apply one accepted request word to the mirrored state and return the
    // result word the block owes for it. The waiting test comes first, so a
    // task already in the queue is refused even when the mutex is free.
    function automatic result_t next_mutex_result(request_t w);
        result_t     r;
        int unsigned slot;
        r.status      = ST_ACQUIRED;
        r.woken_task  = '0;
        r.woken_valid = 1'b0;
        if (w.command == CMD_LOCK)
        begin
            if (waiter_mask[w.task_id])
                r.status = ST_ALREADY;
            else if (!held)
            begin
                held     = 1'b1;
                r.status = ST_ACQUIRED;
            end
            else if (waiter_count >= MAX_TASKS)
                r.status = ST_FULL;
            else
            begin
                // No owner is kept, so the holder itself queues like anyone else.
                slot                  = (head_idx + waiter_count) % MAX_TASKS;
                waitlist[slot]        = w.task_id;
                waiter_count          = waiter_count + 1;
                waiter_mask[w.task_id] = 1'b1;
                r.status              = ST_QUEUED;
            end
        end
        else
        begin
            // Unlock ignores task_id: any task may release.
            if (!held)
                r.status = ST_NOT_LOCKED;
            else if (waiter_count != 0)
            begin
                r.woken_task              = waitlist[head_idx];
                r.woken_valid             = 1'b1;
                head_idx                  = (head_idx + 1) % MAX_TASKS;
                waiter_count              = waiter_count - 1;
                waiter_mask[r.woken_task] = 1'b0;
                r.status                  = ST_HANDED_OFF;
            end
            else
            begin
                held     = 1'b0;
                r.status = ST_RELEASED;
            end
        end
        return r;
    endfunction

    function automatic void add_row(cmd_t c, logic [ID_W-1:0] id, bit typed,
                                    status_t st, logic [ID_W-1:0] wk, logic wv);
        stim_row_t row;
        row.word.command    = c;
        row.word.task_id    = id;
        row.typed           = typed;
        row.want.status     = st;
        row.want.woken_task = wk;
        row.want.woken_valid = wv;
        stim_table.push_back(row);
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned exp);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, exp);
        error_count++;
    endtask

    // Offer one request word, optionally after a gap, and hold it until taken.
    // Valid stays high across back-to-back words; it drops only for a gap.
    task automatic send_word(request_t w, bit typed, result_t want);
        int      gap;
        result_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        // Accepted at this edge: advance the mirror in acceptance order.
        predicted = next_mutex_result(w);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Request side: directed table, then random traffic, then drain and verdict.
    initial
    begin
        request_t w;
        result_t  unused;
        int       lock_pct;

        req_valid    = 1'b0;
        req          = '0;
        held         = 1'b0;
        head_idx     = 0;
        waiter_count = 0;
        waiter_mask  = '0;
        unused       = '0;
        lock_pct     = 50;

        // Unlock of a free mutex, acquire, release by a task that never locked.
        add_row(CMD_UNLOCK, 4'd0,  1'b1, ST_NOT_LOCKED, 4'd0,  1'b0);
        add_row(CMD_LOCK,   4'd0,  1'b1, ST_ACQUIRED,   4'd0,  1'b0);
        add_row(CMD_UNLOCK, 4'd5,  1'b1, ST_RELEASED,   4'd0,  1'b0);
        // The holder locks again and is queued; a second try is a deadlock.
        add_row(CMD_LOCK,   4'd15, 1'b1, ST_ACQUIRED,   4'd0,  1'b0);
        add_row(CMD_LOCK,   4'd15, 1'b1, ST_QUEUED,     4'd0,  1'b0);
        add_row(CMD_LOCK,   4'd15, 1'b1, ST_ALREADY,    4'd0,  1'b0);
        add_row(CMD_UNLOCK, 4'd3,  1'b1, ST_HANDED_OFF, 4'd15, 1'b1);
        // Fill the wait list with every task id. With as many slots as ids,
        // a full queue means every id waits, so the deadlock test always
        // wins over the full test.
        for (int t = 0; t < ID_SPACE; t++)
            add_row(CMD_LOCK, t[ID_W-1:0], 1'b0, ST_QUEUED, 4'd0, 1'b0);
        add_row(CMD_LOCK,   4'd9,  1'b1, ST_ALREADY,    4'd0,  1'b0);
        add_row(CMD_UNLOCK, 4'd12, 1'b1, ST_HANDED_OFF, 4'd0,  1'b1);

        while (rst_n !== 1'b1)
            @(posedge clk);

        foreach (stim_table[i])
            send_word(stim_table[i].word, stim_table[i].typed, stim_table[i].want);

        // Random traffic in blocks with a varying lock bias, so the wait list
        // sweeps from empty to full and back; some blocks run with no gaps.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 100 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       lock_pct = 25;
                    1:       lock_pct = 50;
                    2:       lock_pct = 70;
                    default: lock_pct = 90;
                endcase
                no_idle = ($urandom_range(0, 3) == 0);
            end
            w.command = ($urandom_range(0, 99) < lock_pct) ? CMD_LOCK : CMD_UNLOCK;
            w.task_id = ID_W'($urandom_range(0, ID_SPACE - 1));
            send_word(w, 1'b0, unused);
        end

        req_valid <= 1'b0;
        no_idle   = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // Let any stray result word show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off so the input backs up.
    initial
    begin
        bit held_off;
        int gap;
        held_off  = 1'b0;
        rsp_ready = 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (!held_off && results_seen >= HOLD_OFF_AFTER)
            begin
                held_off = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            gap = pick_gap();
            if (gap > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Check every accepted result word against the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_ready === 1'b1)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result word, status", rsp.status, 0);
            else
            begin
                want = pending_results.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", rsp.status, want.status);
                if (rsp.woken_task !== want.woken_task)
                    report_mismatch("woken_task", rsp.woken_task, want.woken_task);
                if (rsp.woken_valid !== want.woken_valid)
                    report_mismatch("woken_valid", rsp.woken_valid, want.woken_valid);
            end
        end
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/mwfw_pkg.sv
rtl/core/mwfw_waitlist.sv
rtl/core/mutex_with_fifo_waitlist_core.sv
tb/tb_mutex_with_fifo_waitlist_core.sv
